// ----- rtl/fth_pkg.sv -----
package fth_pkg;

    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] MIX_ADD  = 32'he6546b64;
    localparam logic [31:0] FIN_C1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2   = 32'hc2b2ae35;
    localparam logic [31:0] KEY_LEN  = 32'd12;

    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int          ADDR_W        = 3;
    localparam logic [ADDR_W-1:0] REG_SEED_ADDR = 3'd0;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int          PIPE_STAGES = 8;

    // The three key words handed from the front to the hash pipeline.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ports;
    } t_flow_words;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- rtl/flow_tuple_murmur_hash_top.sv -----
// Channel   Handshake                  Payload
// input     i_valid / o_stall          i_src_ip, i_dst_ip, i_ip_protocol, i_src_port,
//                                      i_dst_port, i_ports_present
// output    o_valid / i_stall          o_flow_hash
// config    psel, penable, pwrite      paddr, pwdata, prdata (hash_seed at address 0)
//
// One transaction per cycle is sustained while i_stall is low; each one passes through the queue
// and then through the eight-stage multiply pipeline of the back end.
// A four-entry queue sits between the classifier and the pipeline.
// Reset is synchronous and active low; it empties the queue and clears the seed.
// While a result is stalled the whole pipeline holds and the queue absorbs up to
// four more transactions before o_stall rises.
module flow_tuple_murmur_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [7:0]  i_ip_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic        i_ports_present,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_flow_hash,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [fth_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fth_pkg::*;

    logic [31:0]   r_seed;
    logic          push;
    logic          pop;
    t_flow_words   front_words;
    t_flow_words   queue_words;
    t_queue_status queue_status;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SEED_ADDR) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && pready && (paddr == REG_SEED_ADDR)) begin
            r_seed <= pwdata;
        end
    end

    fth_front u_front (
        .i_valid         (i_valid),
        .i_src_ip        (i_src_ip),
        .i_dst_ip        (i_dst_ip),
        .i_ip_protocol   (i_ip_protocol),
        .i_src_port      (i_src_port),
        .i_dst_port      (i_dst_port),
        .i_ports_present (i_ports_present),
        .i_queue_status  (queue_status),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_words         (front_words)
    );

    fth_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_words  (front_words),
        .i_pop    (pop),
        .o_words  (queue_words),
        .o_status (queue_status)
    );

    fth_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed         (r_seed),
        .i_words        (queue_words),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_flow_hash    (o_flow_hash)
    );

endmodule

// ----- rtl/fth_front.sv -----
module fth_front (
    input  logic                  i_valid,
    input  logic [31:0]           i_src_ip,
    input  logic [31:0]           i_dst_ip,
    input  logic [7:0]            i_ip_protocol,
    input  logic [15:0]           i_src_port,
    input  logic [15:0]           i_dst_port,
    input  logic                  i_ports_present,
    input  fth_pkg::t_queue_status i_queue_status,
    output logic                  o_stall,
    output logic                  o_push,
    output fth_pkg::t_flow_words  o_words
);
    import fth_pkg::*;

    logic use_ports;

    // Ports count only for TCP and UDP with enough payload to hold them.
    assign use_ports = i_ports_present &&
                       ((i_ip_protocol == PROTO_TCP) || (i_ip_protocol == PROTO_UDP));

    assign o_stall       = i_queue_status.full;
    assign o_push        = i_valid && !i_queue_status.full;
    assign o_words.src   = i_src_ip;
    assign o_words.dst   = i_dst_ip;
    assign o_words.ports = use_ports ? {i_dst_port, i_src_port} : 32'd0;

endmodule

// ----- rtl/fth_queue.sv -----
module fth_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  fth_pkg::t_flow_words   i_words,
    input  logic                   i_pop,
    output fth_pkg::t_flow_words   o_words,
    output fth_pkg::t_queue_status o_status
);
    import fth_pkg::*;

    t_flow_words              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]        r_count, n_count;
    logic                     do_push;
    logic                     do_pop;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_words        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_words;
        end
    end

endmodule

// ----- rtl/fth_back.sv -----
module fth_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_seed,
    input  fth_pkg::t_flow_words   i_words,
    input  fth_pkg::t_queue_status i_queue_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_flow_hash
);
    import fth_pkg::*;

    logic [PIPE_STAGES-1:0] r_vld;
    logic                   adv;

    logic [31:0] r_s1_k0, r_s1_k1, r_s1_k2;
    logic [31:0] r_s2_k0, r_s2_k1, r_s2_k2;
    logic [31:0] r_s3_h,  r_s3_k1, r_s3_k2;
    logic [31:0] r_s4_h,  r_s4_k2;
    logic [31:0] r_s5_h;
    logic [31:0] r_s6_h;
    logic [31:0] r_s7_h;
    logic [31:0] r_s8_h;

    logic [31:0] n_s3_h, n_s4_h, n_s5_h, n_s6_h, n_s7_h;
    logic [31:0] fin_a, fin_b;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    // acc ^= k; acc = rotl(acc, 13); acc * 5 + constant (the *5 is a shift-add).
    function automatic logic [31:0] mix_acc(input logic [31:0] acc, input logic [31:0] k);
        logic [31:0] t;
        logic [31:0] r;
        t = acc ^ k;
        r = {t[18:0], t[31:19]};
        return (r + {r[29:0], 2'b00}) + MIX_ADD;
    endfunction

    // The whole pipe moves together; it halts only while a finished hash waits.
    assign adv         = !r_vld[PIPE_STAGES-1] || !i_stall;
    assign o_pop       = adv && !i_queue_status.empty;
    assign o_valid     = r_vld[PIPE_STAGES-1];
    assign o_flow_hash = r_s8_h;

    assign n_s3_h = mix_acc(i_seed, r_s2_k0);
    assign n_s4_h = mix_acc(r_s3_h, r_s3_k1);
    assign n_s5_h = mix_acc(r_s4_h, r_s4_k2);
    assign fin_a  = r_s5_h ^ KEY_LEN;
    assign n_s6_h = fin_a ^ (fin_a >> 16);
    assign fin_b  = r_s6_h ^ (r_s6_h >> 13);
    assign n_s7_h = r_s7_h ^ (r_s7_h >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], !i_queue_status.empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_k0 <= i_words.src * MIX_C1;
            r_s1_k1 <= i_words.dst * MIX_C1;
            r_s1_k2 <= i_words.ports * MIX_C1;

            r_s2_k0 <= rotl15(r_s1_k0) * MIX_C2;
            r_s2_k1 <= rotl15(r_s1_k1) * MIX_C2;
            r_s2_k2 <= rotl15(r_s1_k2) * MIX_C2;

            r_s3_h  <= n_s3_h;
            r_s3_k1 <= r_s2_k1;
            r_s3_k2 <= r_s2_k2;

            r_s4_h  <= n_s4_h;
            r_s4_k2 <= r_s3_k2;

            r_s5_h  <= n_s5_h;

            r_s6_h  <= n_s6_h * FIN_C1;
            r_s7_h  <= fin_b * FIN_C2;
            r_s8_h  <= n_s7_h;
        end
    end

endmodule

// ----- rtl/fth_checker.sv -----
module fth_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_flow_hash,
    input  logic        pready
);

    // A result leaves reset cleared.
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // A stalled result stays put.
    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_flow_hash)))
        else $error("stalled result changed");

    // The queue can only fill while a finished result is held back.
    a_stall_needs_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output is idle");

    a_config_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind flow_tuple_murmur_hash_top fth_checker u_fth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_flow_hash (o_flow_hash),
    .pready      (pready)
);

// ----- dv/flow_tuple_murmur_hash_checker.sv -----
module flow_tuple_murmur_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [7:0]  i_ip_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic        i_ports_present,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_flow_hash,

    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [fth_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,

    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] BLOCK_MUL1 = 32'hcc9e2d51;
    localparam logic [31:0] BLOCK_MUL2 = 32'h1b873593;
    localparam logic [31:0] BLOCK_ADD  = 32'he6546b64;
    localparam logic [31:0] AVAL_MUL1  = 32'h85ebca6b;
    localparam logic [31:0] AVAL_MUL2  = 32'hc2b2ae35;
    localparam logic [31:0] KEY_BYTES  = 32'd12;
    localparam logic [7:0]  IPPROTO_TCP = 8'd6;
    localparam logic [7:0]  IPPROTO_UDP = 8'd17;
    localparam int          MAX_REPORTS = 10;

    logic [31:0] node_seed;
    logic [31:0] expected_hashes[$];
    int          mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_hashes.size();

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] absorb_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] m;
        m = k * BLOCK_MUL1;
        m = rotl32(m, 15);
        m = m * BLOCK_MUL2;
        h = rotl32(h ^ m, 13);
        return h * 32'd5 + BLOCK_ADD;
    endfunction

    function automatic logic [31:0] flow_hash_of(
        input logic [31:0] seed,
        input logic [31:0] src,
        input logic [31:0] dst,
        input logic [7:0]  proto,
        input logic [15:0] sport,
        input logic [15:0] dport,
        input logic        present
    );
        logic [31:0] port_word;
        logic [31:0] h;
        port_word = 32'd0;
        // Ports only count for TCP and UDP with the port bytes actually there.
        if (present && (proto == IPPROTO_TCP || proto == IPPROTO_UDP)) begin
            port_word = {dport, sport};
        end
        h = absorb_word(seed, src);
        h = absorb_word(h, dst);
        h = absorb_word(h, port_word);
        h = h ^ KEY_BYTES;
        h = h ^ (h >> 16);
        h = h * AVAL_MUL1;
        h = h ^ (h >> 13);
        h = h * AVAL_MUL2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %08h, got %08h", $realtime, what,
                     exp_val, act_val);
        end
        mismatches++;
    endtask

    initial begin
        node_seed  = 32'd0;
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_seed = 32'd0;
            expected_hashes.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_hashes = {expected_hashes, flow_hash_of(node_seed, i_src_ip,
                    i_dst_ip, i_ip_protocol, i_src_port, i_dst_port, i_ports_present)};
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_hashes.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: unexpected hash transaction %08h", $realtime,
                                 i_flow_hash);
                    end
                    mismatches++;
                end else begin
                    logic [31:0] want;
                    want = expected_hashes.pop_front();
                    if (i_flow_hash !== want) begin
                        flag_mismatch("flow_hash", want, i_flow_hash);
                    end
                end
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == fth_pkg::REG_SEED_ADDR) begin
                        node_seed = i_pwdata;
                    end
                end else if (i_paddr == fth_pkg::REG_SEED_ADDR) begin
                    if (i_prdata !== node_seed) begin
                        flag_mismatch("hash_seed readback", node_seed, i_prdata);
                    end
                end
            end
        end
    end

endmodule

// ----- dv/flow_tuple_murmur_hash_top_test.sv -----
module flow_tuple_murmur_hash_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fth_pkg::*;

    // Byte address of register index 1, which does not exist.
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
    localparam int  RANDOM_PER_SEED = 250;
    localparam int  DRAIN_CYCLES    = 16;
    localparam int  IDLE_LIMIT      = 2000;

    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        present;
    } t_flow_tuple;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_src_ip = '0;
    logic [31:0] i_dst_ip = '0;
    logic [7:0]  i_ip_protocol = '0;
    logic [15:0] i_src_port = '0;
    logic [15:0] i_dst_port = '0;
    logic        i_ports_present = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_flow_hash;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int hashes_pending;
    int flows_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit long_hold_done = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    flow_tuple_murmur_hash_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_src_ip        (i_src_ip),
        .i_dst_ip        (i_dst_ip),
        .i_ip_protocol   (i_ip_protocol),
        .i_src_port      (i_src_port),
        .i_dst_port      (i_dst_port),
        .i_ports_present (i_ports_present),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_flow_hash     (o_flow_hash),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    flow_tuple_murmur_hash_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_src_ip        (i_src_ip),
        .i_dst_ip        (i_dst_ip),
        .i_ip_protocol   (i_ip_protocol),
        .i_src_port      (i_src_port),
        .i_dst_port      (i_dst_port),
        .i_ports_present (i_ports_present),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_flow_hash     (o_flow_hash),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (hashes_pending)
    );

    function automatic t_flow_tuple make_tuple(
        input logic [31:0] src, input logic [31:0] dst, input logic [7:0] proto,
        input logic [15:0] sport, input logic [15:0] dport, input logic present
    );
        t_flow_tuple t;
        t.src     = src;
        t.dst     = dst;
        t.proto   = proto;
        t.sport   = sport;
        t.dport   = dport;
        t.present = present;
        return t;
    endfunction

    // Mostly TCP and UDP flows with their ports, plus other protocols and
    // short packets so that the port word is also forced to zero.
    function automatic t_flow_tuple random_tuple();
        t_flow_tuple t;
        int pick;
        t.src   = $urandom();
        t.dst   = $urandom();
        t.sport = 16'($urandom_range(0, 65535));
        t.dport = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            t.proto = PROTO_TCP;
        end else if (pick < 7) begin
            t.proto = PROTO_UDP;
        end else begin
            t.proto = 8'($urandom_range(0, 255));
        end
        t.present = ($urandom_range(0, 9) < 8);
        if ($urandom_range(0, 19) == 0) begin
            t.src = ($urandom_range(0, 1) == 1) ? 32'hffffffff : 32'h0;
        end
        if ($urandom_range(0, 19) == 0) begin
            t.dst = ($urandom_range(0, 1) == 1) ? 32'hffffffff : 32'h0;
        end
        return t;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic offer_flow(input t_flow_tuple t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid         <= 1'b1;
        i_src_ip        <= t.src;
        i_dst_ip        <= t.dst;
        i_ip_protocol   <= t.proto;
        i_src_port      <= t.sport;
        i_dst_port      <= t.dport;
        i_ports_present <= t.present;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        flows_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The task waits for a clock edge first so that the last accepted transaction is counted.
    task automatic drain_hashes();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        wait (hashes_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_node_seed(input logic [31:0] seed);
        apb_access(1'b1, REG_SEED_ADDR, seed);
        apb_access(1'b0, REG_SEED_ADDR, 32'd0);
    endtask

    initial begin
        t_flow_tuple  directed[$];
        logic [31:0]  seeds[$];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A write to an address with no register must leave the seed at zero.
        apb_access(1'b1, UNMAPPED_ADDR, 32'hdeadbeef);
        apb_access(1'b0, REG_SEED_ADDR, 32'd0);

        directed = {directed, make_tuple(32'h0, 32'h0, 8'd0, 16'h0, 16'h0, 1'b0)};
        directed = {directed, make_tuple('1, '1, 8'hff, 16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple('1, '1, PROTO_TCP, 16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple('1, '1, PROTO_UDP, 16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple(32'h0a000001, 32'h0a000002, PROTO_TCP,
                                         16'd1234, 16'd80, 1'b1)};
        directed = {directed, make_tuple(32'h0a000001, 32'h0a000002, PROTO_TCP,
                                         16'd1234, 16'd80, 1'b0)};
        directed = {directed, make_tuple(32'hc0a80001, 32'h08080808, PROTO_UDP,
                                         16'd5353, 16'd53, 1'b1)};
        directed = {directed, make_tuple(32'hc0a80001, 32'h08080808, PROTO_UDP,
                                         16'd5353, 16'd53, 1'b0)};
        directed = {directed, make_tuple(32'h12345678, 32'h9abcdef0, 8'd5,
                                         16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple(32'h12345678, 32'h9abcdef0, 8'd7,
                                         16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple(32'h12345678, 32'h9abcdef0, 8'd16,
                                         16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple(32'h12345678, 32'h9abcdef0, 8'd18,
                                         16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple(32'h0, 32'h0, 8'd0, 16'hffff, 16'hffff, 1'b1)};
        directed = {directed, make_tuple('1, 32'h0, PROTO_TCP, 16'hffff, 16'h0, 1'b1)};
        directed = {directed, make_tuple(32'h0, '1, PROTO_UDP, 16'h0, 16'hffff, 1'b1)};
        directed = {directed, make_tuple(32'h0, 32'h0, PROTO_TCP, 16'h0, 16'h0, 1'b1)};
        directed = {directed, make_tuple(32'h80000000, 32'h00000001, 8'hff,
                                         16'h8001, 16'h7ffe, 1'b0)};
        directed = {directed, make_tuple(32'haaaaaaaa, 32'h55555555, PROTO_UDP,
                                         16'haaaa, 16'h5555, 1'b1)};
        foreach (directed[k]) begin
            offer_flow(directed[k]);
        end
        drain_hashes();

        seeds = '{32'hffffffff, 32'h00000000, $urandom(), 32'h00000001, $urandom(),
                  32'h80000000, $urandom()};
        foreach (seeds[s]) begin
            set_node_seed(seeds[s]);
            repeat (RANDOM_PER_SEED) offer_flow(random_tuple());
            drain_hashes();
        end

        if (fail_count == 0 && hashes_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver back-pressure: free-flowing stretches, random stalls and long
    // hold-offs; one early hold-off lets the queue fill and stall the input.
    initial begin
        int mode;
        int span;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && flows_sent >= 300) begin
                long_hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (64) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 9);
                span = $urandom_range(10, 60);
                if (mode == 0) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(30, 80)) @(posedge i_clk);
                end else if (mode <= 3) begin
                    i_stall <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end else begin
                    repeat (span) begin
                        i_stall <= ($urandom_range(0, 99) < 35);
                        @(posedge i_clk);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
rtl/fth_pkg.sv
rtl/fth_front.sv
rtl/fth_queue.sv
rtl/fth_back.sv
rtl/flow_tuple_murmur_hash_top.sv
rtl/fth_checker.sv
dv/flow_tuple_murmur_hash_checker.sv
dv/flow_tuple_murmur_hash_top_test.sv
